// File: rtl/rect_alpha_blend_fill_macros.svh
// assertion helpers used by the checker file
`ifndef RECT_ALPHA_BLEND_FILL_MACROS_SVH
`define RECT_ALPHA_BLEND_FILL_MACROS_SVH

// checked only outside reset
`define RABF_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("rect_alpha_blend_fill check failed");

// checked at every edge, reset included
`define RABF_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("rect_alpha_blend_fill check failed");

`endif

// File: rtl/rabf_pkg.sv
package rabf_pkg;

   // screen size used for clipping
   localparam int SCREEN_WIDTH  = 1024;
   localparam int SCREEN_HEIGHT = 1024;

   // field widths
   localparam int PIX_COORD_W = 12;
   localparam int COORD_W     = 13;
   localparam int PIXEL_W     = 32;
   localparam int CH_W        = 8;
   localparam int LANES       = 3;
   localparam int PROD_W      = 2 * CH_W;
   localparam int DIV_W       = 16;
   localparam int NUM_W       = 24;
   localparam int Q_W         = 8;
   localparam int DIV_STAGES  = Q_W;
   localparam int PIPE_STAGES = DIV_STAGES + 2;

   localparam logic [CH_W-1:0] MAX_U8 = 8'hFF;

   // config port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FILL_COLOR    = 3'd0,
      REG_EDGE_X_A      = 3'd1,
      REG_EDGE_X_B      = 3'd2,
      REG_EDGE_Y_A      = 3'd3,
      REG_EDGE_Y_B      = 3'd4,
      REG_OUTLINE_MODE  = 3'd5,
      REG_OUTLINE_THICK = 3'd6
   } rabf_reg_type;

   typedef struct packed {
      logic [PIX_COORD_W-1:0] pixel_x;
      logic [PIX_COORD_W-1:0] pixel_y;
      logic [PIXEL_W-1:0]     pixel_in;
   } rabf_req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               covered;
   } rabf_rsp_type;

   // data that rides along the divider stages
   typedef struct packed {
      logic               covered;
      logic               zero;
      logic [CH_W-1:0]    alpha;
      logic [PIXEL_W-1:0] pixel;
   } rabf_side_type;

endpackage

// File: rtl/rect_alpha_blend_fill.sv
// channel   dir  handshake            payload
// req       in   req_valid/req_stall  pixel_x, pixel_y, pixel_in
// rsp       out  rsp_valid/rsp_stall  pixel_out, covered
// csr       in   csr_we               csr_index, csr_wdata
//
// one pixel per clock sustained while rsp_stall is low; ten register stages, from
// the stage 0 register that takes the req transfer to the last one, which drives rsp_valid
// two stages for region test and blend products, then eight divider stages
// that produce one quotient bit each for the three color channels
// reset is synchronous, clears valid bits and loads register defaults
// a stall holds only the stages that are full; bubbles still move up
module rect_alpha_blend_fill (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rabf_pkg::rabf_req_type              req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rabf_pkg::rabf_rsp_type              rsp_payload,
   input  logic                                csr_we,
   input  logic [rabf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rabf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rabf_pkg::*;

   localparam int LAST = PIPE_STAGES - 1;
   localparam logic [COORD_W-1:0] SCR_W = COORD_W'(SCREEN_WIDTH);
   localparam logic [COORD_W-1:0] SCR_H = COORD_W'(SCREEN_HEIGHT);

   // config registers
   logic [PIXEL_W-1:0] fill_color_ff;
   logic [COORD_W-1:0] edge_x_a_ff, edge_x_b_ff, edge_y_a_ff, edge_y_b_ff;
   logic               outline_mode_ff;
   logic [COORD_W-1:0] outline_thick_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_color_ff    <= '0;
         edge_x_a_ff      <= '0;
         edge_x_b_ff      <= '0;
         edge_y_a_ff      <= '0;
         edge_y_b_ff      <= '0;
         outline_mode_ff  <= 1'b0;
         outline_thick_ff <= COORD_W'(1);
      end else if (csr_we) begin
         case (rabf_reg_type'(csr_index))
            REG_FILL_COLOR:    fill_color_ff    <= csr_wdata;
            REG_EDGE_X_A:      edge_x_a_ff      <= csr_wdata[COORD_W-1:0];
            REG_EDGE_X_B:      edge_x_b_ff      <= csr_wdata[COORD_W-1:0];
            REG_EDGE_Y_A:      edge_y_a_ff      <= csr_wdata[COORD_W-1:0];
            REG_EDGE_Y_B:      edge_y_b_ff      <= csr_wdata[COORD_W-1:0];
            REG_OUTLINE_MODE:  outline_mode_ff  <= csr_wdata[0];
            REG_OUTLINE_THICK: outline_thick_ff <= csr_wdata[COORD_W-1:0];
            default: ;
         endcase
      end
   end

   // stage enables: a stage moves when empty or when the next one moves
   logic [PIPE_STAGES-1:0] v_ff;
   logic [PIPE_STAGES-1:0] en;

   always_comb begin
      en[LAST] = !v_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < PIPE_STAGES; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_stall = !en[0];

   // stage 0: rectangle bounds and first products
   logic [COORD_W-1:0] x_lo, x_hi, y_lo, y_hi, x_end, y_end, dx, dy, t_in;
   logic [CH_W-1:0]    at, ab;
   logic [PROD_W-1:0]  wb_in, at255_in;
   logic [LANES-1:0][PROD_W-1:0] ctat_in;

   always_comb begin
      x_lo  = (edge_x_a_ff < edge_x_b_ff) ? edge_x_a_ff : edge_x_b_ff;
      x_hi  = (edge_x_a_ff < edge_x_b_ff) ? edge_x_b_ff : edge_x_a_ff;
      y_lo  = (edge_y_a_ff < edge_y_b_ff) ? edge_y_a_ff : edge_y_b_ff;
      y_hi  = (edge_y_a_ff < edge_y_b_ff) ? edge_y_b_ff : edge_y_a_ff;
      x_end = (x_hi < SCR_W) ? x_hi : SCR_W;
      y_end = (y_hi < SCR_H) ? y_hi : SCR_H;
      dx    = x_hi - x_lo;
      dy    = y_hi - y_lo;
      t_in  = outline_thick_ff;
      if (dx < t_in) t_in = dx;
      if (dy < t_in) t_in = dy;
   end

   assign at       = fill_color_ff[PIXEL_W-1 -: CH_W];
   assign ab       = req_payload.pixel_in[PIXEL_W-1 -: CH_W];
   assign wb_in    = PROD_W'(ab) * PROD_W'(MAX_U8 - at);
   assign at255_in = {at, {CH_W{1'b0}}} - PROD_W'(at);

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         ctat_in[c] = PROD_W'(fill_color_ff[c*CH_W +: CH_W]) * PROD_W'(at);
      end
   end

   logic [PIX_COORD_W-1:0]       s0_x_ff, s0_y_ff;
   logic [PIXEL_W-1:0]           s0_pix_ff;
   logic [COORD_W-1:0]           s0_bx_ff, s0_ex_ff, s0_by_ff, s0_ey_ff, s0_t_ff;
   logic [PROD_W-1:0]            s0_wb_ff, s0_at255_ff;
   logic [LANES-1:0][PROD_W-1:0] s0_ctat_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_x_ff     <= req_payload.pixel_x;
         s0_y_ff     <= req_payload.pixel_y;
         s0_pix_ff   <= req_payload.pixel_in;
         s0_bx_ff    <= x_lo;
         s0_ex_ff    <= x_end;
         s0_by_ff    <= y_lo;
         s0_ey_ff    <= y_end;
         s0_t_ff     <= t_in;
         s0_wb_ff    <= wb_in;
         s0_at255_ff <= at255_in;
         s0_ctat_ff  <= ctat_in;
      end
   end

   // stage 1: coverage test, blend numerators, divisor and output alpha
   logic [COORD_W-1:0]          xe, ye;
   logic [COORD_W:0]            x_sum, y_sum, bx_t, by_t;
   logic                        in_rect, band;
   logic [DIV_W-1:0]            s_in;
   logic [DIV_W:0]              alpha_sum;
   logic [LANES-1:0][NUM_W-1:0] num_in;
   rabf_side_type               side_in;

   assign xe    = COORD_W'(s0_x_ff);
   assign ye    = COORD_W'(s0_y_ff);
   assign x_sum = (COORD_W+1)'(xe) + (COORD_W+1)'(s0_t_ff);
   assign y_sum = (COORD_W+1)'(ye) + (COORD_W+1)'(s0_t_ff);
   assign bx_t  = (COORD_W+1)'(s0_bx_ff) + (COORD_W+1)'(s0_t_ff);
   assign by_t  = (COORD_W+1)'(s0_by_ff) + (COORD_W+1)'(s0_t_ff);

   assign in_rect = (xe >= s0_bx_ff) && (xe < s0_ex_ff) &&
                    (ye >= s0_by_ff) && (ye < s0_ey_ff);
   // band test with far edges moved to the sum side to stay non-negative
   assign band   = ((COORD_W+1)'(ye) < by_t) || (y_sum >= (COORD_W+1)'(s0_ey_ff)) ||
                   ((COORD_W+1)'(xe) < bx_t) || (x_sum >= (COORD_W+1)'(s0_ex_ff));

   assign s_in      = s0_at255_ff + s0_wb_ff;
   // floor(s / 255) for s below 65535
   assign alpha_sum = (DIV_W+1)'(s_in) + (DIV_W+1)'(s_in >> CH_W) + (DIV_W+1)'(1);

   always_comb begin
      for (int c = 0; c < LANES; c++) begin
         num_in[c] = ({s0_ctat_ff[c], {CH_W{1'b0}}} - NUM_W'(s0_ctat_ff[c]))
                   + NUM_W'(s0_pix_ff[c*CH_W +: CH_W]) * NUM_W'(s0_wb_ff);
      end
      side_in.covered = in_rect && (!outline_mode_ff || band);
      side_in.zero    = (s_in == '0);
      side_in.alpha   = alpha_sum[CH_W +: CH_W];
      side_in.pixel   = s0_pix_ff;
   end

   logic [DIV_W-1:0]            s1_s_ff;
   logic [LANES-1:0][NUM_W-1:0] s1_num_ff;
   rabf_side_type               s1_side_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_s_ff    <= s_in;
         s1_num_ff  <= num_in;
         s1_side_ff <= side_in;
      end
   end

   // channel divide
   logic [LANES-1:0][Q_W-1:0] q_out;
   rabf_side_type             side_out;

   rabf_div u_div (
      .clock        (clock),
      .en           (en[LAST:2]),
      .div_s        (s1_s_ff),
      .div_num      (s1_num_ff),
      .div_side     (s1_side_ff),
      .div_q        (q_out),
      .div_side_out (side_out)
   );

   // result select
   always_comb begin
      rsp_payload.covered = side_out.covered;
      if (!side_out.covered) begin
         rsp_payload.pixel_out = side_out.pixel;
      end else if (side_out.zero) begin
         rsp_payload.pixel_out = '0;
      end else begin
         rsp_payload.pixel_out = {side_out.alpha, q_out[2], q_out[1], q_out[0]};
      end
   end

   assign rsp_valid = v_ff[LAST];

endmodule

// File: rtl/rabf_div.sv
module rabf_div (
   input  logic                                                clock,
   input  logic [rabf_pkg::DIV_STAGES-1:0]                     en,
   input  logic [rabf_pkg::DIV_W-1:0]                          div_s,
   input  logic [rabf_pkg::LANES-1:0][rabf_pkg::NUM_W-1:0]     div_num,
   input  rabf_pkg::rabf_side_type                             div_side,
   output logic [rabf_pkg::LANES-1:0][rabf_pkg::Q_W-1:0]       div_q,
   output rabf_pkg::rabf_side_type                             div_side_out
);
   import rabf_pkg::*;

   localparam int LAST = DIV_STAGES - 1;

   logic [DIV_W-1:0]                  s_ff    [LAST];
   rabf_side_type                     side_ff [DIV_STAGES];
   logic [LANES-1:0][Q_W-1:0]         q_ff    [DIV_STAGES];
   logic [LANES-1:0][NUM_W-1:0]       rem_ff  [LAST];

   // one quotient bit per stage, msb first, three lanes side by side
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int SH = LAST - k;

      logic [DIV_W-1:0]            s_prev;
      rabf_side_type               side_prev;
      logic [LANES-1:0][NUM_W-1:0] rem_prev;
      logic [LANES-1:0][Q_W-1:0]   q_prev;
      logic [NUM_W-1:0]            dsh;
      logic [LANES-1:0][NUM_W-1:0] rem_in;
      logic [LANES-1:0][Q_W-1:0]   q_in;

      if (k == 0) begin : g_first
         assign s_prev    = div_s;
         assign side_prev = div_side;
         assign rem_prev  = div_num;
         assign q_prev    = '0;
      end else begin : g_next
         assign s_prev    = s_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign q_prev    = q_ff[k-1];
      end

      // shifted divisor for this bit position
      assign dsh = NUM_W'(s_prev) << SH;

      // trial subtract per lane
      always_comb begin
         rem_in = rem_prev;
         q_in   = q_prev;
         for (int l = 0; l < LANES; l++) begin
            if (rem_prev[l] >= dsh) begin
               rem_in[l]   = rem_prev[l] - dsh;
               q_in[l][SH] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            side_ff[k] <= side_prev;
            q_ff[k]    <= q_in;
         end
      end

      // the last stage needs no remainder and no divisor
      if (k < LAST) begin : g_rem
         always_ff @(posedge clock) begin
            if (en[k]) begin
               s_ff[k]   <= s_prev;
               rem_ff[k] <= rem_in;
            end
         end
      end
   end

   assign div_q        = q_ff[LAST];
   assign div_side_out = side_ff[LAST];

endmodule

// File: rtl/rabf_checker.sv
`include "rect_alpha_blend_fill_macros.svh"

module rabf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rabf_pkg::rabf_rsp_type rsp_payload
);

   // a held result keeps its value
   `RABF_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))

   // with the output stage empty the input never backs up
   `RABF_ASSERT(a_no_false_stall, !rsp_valid |-> !req_stall)

   // zero output alpha on a blended pixel means a fully clear pixel
   `RABF_ASSERT(a_clear_pixel,
      rsp_valid && rsp_payload.covered && (rsp_payload.pixel_out[31:24] == 8'd0)
      |-> (rsp_payload.pixel_out == 32'd0))

   // nothing comes out right after reset
   `RABF_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

endmodule

bind rect_alpha_blend_fill rabf_checker u_rabf_checker (.*);
